// File: rtl/amr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_pkg
// Shared types, constants and compare helpers for the argmin reducer.
// ----------------------------------------------------------------------------
package amr_pkg;

  localparam int AMR_MAX_INNER  = 1024;
  localparam int AMR_ELEM_WIDTH = 64;

  localparam int DATA_W      = 64;
  localparam int POS_W       = 16;
  localparam int AXIS_LEN_W  = 17;
  localparam int INNER_CNT_W = 11;
  localparam int KIND_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int CNT_CMP_W   = 17;

  localparam logic [KIND_W-1:0] KIND_UNSIGNED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SIGNED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HALF     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SINGLE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DOUBLE   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_KIND   = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
  } entry_t;

  // IEEE ordering on raw bits: NaN never less, signed zeros equal.
  function automatic logic fp_less(logic [63:0] a, logic [63:0] b,
                                   logic [6:0] width, logic [5:0] mant_bits);
    logic [63:0] all_m;
    logic [63:0] sign_m;
    logic [63:0] mant_m;
    logic [63:0] expo_m;
    logic [63:0] am;
    logic [63:0] bm;
    logic [63:0] ka;
    logic [63:0] kb;
    logic        a_nan;
    logic        b_nan;
    all_m  = ~64'd0 >> (7'd64 - width);
    sign_m = 64'd1 << (width - 7'd1);
    mant_m = (64'd1 << mant_bits) - 64'd1;
    expo_m = all_m & ~sign_m & ~mant_m;
    am     = a & all_m;
    bm     = b & all_m;
    a_nan  = ((am & expo_m) == expo_m) && ((am & mant_m) != 64'd0);
    b_nan  = ((bm & expo_m) == expo_m) && ((bm & mant_m) != 64'd0);
    ka     = ((am & sign_m) != 64'd0) ? (~am & all_m) : (am | sign_m);
    kb     = ((bm & sign_m) != 64'd0) ? (~bm & all_m) : (bm | sign_m);
    if (a_nan || b_nan) begin
      return 1'b0;
    end
    if (((am & ~sign_m) == 64'd0) && ((bm & ~sign_m) == 64'd0)) begin
      return 1'b0;
    end
    return ka < kb;
  endfunction

endpackage

// File: rtl/amr_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_compare
// Strict less-than of a new element against the stored best, per data kind.
// ----------------------------------------------------------------------------
module amr_compare #(
  parameter int ELEM_WIDTH = amr_pkg::AMR_ELEM_WIDTH
) (
  input  logic [amr_pkg::DATA_W-1:0] elem,
  input  logic [amr_pkg::DATA_W-1:0] best,
  input  logic [amr_pkg::KIND_W-1:0] kind,
  output logic                       less
);
  import amr_pkg::*;

  localparam logic [DATA_W-1:0] INT_MASK = {DATA_W{1'b1}} >> (DATA_W - ELEM_WIDTH);
  localparam logic [DATA_W-1:0] INT_SIGN = {{(DATA_W-1){1'b0}}, 1'b1} << (ELEM_WIDTH - 1);

  always_comb begin
    unique case (kind)
      KIND_SIGNED: less = ((elem & INT_MASK) ^ INT_SIGN) < ((best & INT_MASK) ^ INT_SIGN);
      KIND_HALF:   less = fp_less(elem, best, 7'd16, 6'd10);
      KIND_SINGLE: less = fp_less(elem, best, 7'd32, 6'd23);
      KIND_DOUBLE: less = fp_less(elem, best, 7'd64, 6'd52);
      default:     less = (elem & INT_MASK) < (best & INT_MASK);
    endcase
  end

endmodule

// File: rtl/amr_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_table
// Best value/position store, one write and one registered read per cycle,
// with write-to-read bypass for back-to-back hits on the same slot.
// ----------------------------------------------------------------------------
module amr_table #(
  parameter int DEPTH = amr_pkg::AMR_MAX_INNER,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output amr_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  amr_pkg::entry_t wr_data
);
  import amr_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/axis_argmin_reducer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_argmin_reducer
// Running argmin along one tensor axis, one table entry per inner position.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | in_tdata[63:0]  element_bits
//   out_    | out | out_tvalid/tready  | out_tdata[15:0] min_index
//   cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// One word per cycle while no result is held back; a result word passes the compare stage, then the output register.
// The table read of one word overlaps the compare and write-back of the
// previous one; a same-slot hit is bypassed at the table read register.
// Reset clears counters and loads axis_length 1, inner_count 1, signed.
// The table has no reset; axis position zero loads each entry first.
// A result not taken holds a run-ending word in the compare stage and the input behind it.
// ----------------------------------------------------------------------------
module axis_argmin_reducer #(
  parameter int MAX_INNER  = amr_pkg::AMR_MAX_INNER,
  parameter int ELEM_WIDTH = amr_pkg::AMR_ELEM_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [amr_pkg::DATA_W-1:0]    in_tdata,   // [63:0] element_bits
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [amr_pkg::POS_W-1:0]     out_tdata,  // [15:0] min_index
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [amr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [amr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import amr_pkg::*;

  localparam int IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

  logic [AXIS_LEN_W-1:0]  axis_length_r;
  logic [INNER_CNT_W-1:0] inner_count_r;
  logic [KIND_W-1:0]      data_kind_r;

  logic [POS_W-1:0] axis_ctr_r;
  logic [IW-1:0]    inner_ctr_r;

  logic              s1_v_r;
  logic [DATA_W-1:0] s1_elem_r;
  logic [IW-1:0]     s1_slot_r;
  logic [POS_W-1:0]  s1_pos_r;
  logic              s1_first_r;
  logic              s1_last_r;

  logic             out_tvalid_r;
  logic [POS_W-1:0] out_index_r;

  logic [POS_W-1:0]     alen_m1;
  logic [CNT_CMP_W-1:0] icnt_eff;
  logic                 last;
  logic                 inner_wrap;
  logic                 in_acc;
  logic                 s1_adv;
  logic                 out_free;
  logic                 less;
  logic                 take;
  entry_t               rd_entry;
  entry_t               new_entry;

  always_comb begin
    if (axis_length_r == '0) begin
      alen_m1 = '0;
    end else if (axis_length_r > 17'd65536) begin
      alen_m1 = {POS_W{1'b1}};
    end else begin
      alen_m1 = POS_W'(axis_length_r - 17'd1);
    end
    if (inner_count_r == '0) begin
      icnt_eff = CNT_CMP_W'(1);
    end else if (CNT_CMP_W'(inner_count_r) > CNT_CMP_W'(MAX_INNER)) begin
      icnt_eff = CNT_CMP_W'(MAX_INNER);
    end else begin
      icnt_eff = CNT_CMP_W'(inner_count_r);
    end
  end

  assign last       = axis_ctr_r >= alen_m1;
  assign inner_wrap = (CNT_CMP_W'(inner_ctr_r) + CNT_CMP_W'(1)) >= icnt_eff;
  assign out_free   = !out_tvalid_r || out_tready;
  assign s1_adv     = s1_v_r && (!s1_last_r || out_free);
  assign in_tready  = !s1_v_r || s1_adv;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;

  amr_compare #(
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_compare (
    .elem(s1_elem_r),
    .best(rd_entry.value),
    .kind(data_kind_r),
    .less(less)
  );

  assign take = s1_first_r || less;

  always_comb begin
    if (take) begin
      new_entry.value    = s1_elem_r;
      new_entry.position = s1_pos_r;
    end else begin
      new_entry = rd_entry;
    end
  end

  amr_table #(
    .DEPTH(MAX_INNER),
    .AW(IW)
  ) u_table (
    .clk(clk),
    .rd_en(in_acc),
    .rd_addr(inner_ctr_r),
    .rd_data(rd_entry),
    .wr_en(s1_adv && take),
    .wr_addr(s1_slot_r),
    .wr_data(new_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_length_r <= AXIS_LEN_W'(1);
      inner_count_r <= INNER_CNT_W'(1);
      data_kind_r   <= KIND_SIGNED;
      axis_ctr_r    <= '0;
      inner_ctr_r   <= '0;
      s1_v_r        <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_AXIS_LENGTH: axis_length_r <= cfg_data;
          CFG_INNER_COUNT: inner_count_r <= cfg_data[INNER_CNT_W-1:0];
          CFG_DATA_KIND:   data_kind_r   <= cfg_data[KIND_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        s1_v_r <= 1'b1;
        if (inner_wrap) begin
          inner_ctr_r <= '0;
          axis_ctr_r  <= last ? '0 : axis_ctr_r + POS_W'(1);
        end else begin
          inner_ctr_r <= inner_ctr_r + IW'(1);
        end
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv && s1_last_r) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_elem_r  <= in_tdata;
      s1_slot_r  <= inner_ctr_r;
      s1_pos_r   <= axis_ctr_r;
      s1_first_r <= (axis_ctr_r == '0);
      s1_last_r  <= last;
    end
    if (s1_adv && s1_last_r) begin
      out_index_r <= new_entry.position;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_index_r;

endmodule

// File: tb/argmin_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argmin_checker
// Watches the register, element and result channels of the argmin reducer.
// Keeps its own copy of the registers, the per-position table and the axis
// and inner counters, predicts the min_index word that each run-ending element
// word causes, and compares every result word with the oldest predicted one.
// Hands the mismatch count and the number of outstanding predictions up.
// ----------------------------------------------------------------------------
module argmin_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [amr_pkg::DATA_W-1:0]     in_tdata,   // [63:0] element_bits
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [amr_pkg::POS_W-1:0]      out_tdata,  // [15:0] min_index
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [amr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [amr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending
);
  import amr_pkg::*;

  localparam int          MAX_AXIS  = 65536;
  localparam logic [63:0] ELEM_MASK = {64{1'b1}} >> (64 - AMR_ELEM_WIDTH);
  localparam logic [63:0] ELEM_SIGN = 64'd1 << (AMR_ELEM_WIDTH - 1);

  logic [AXIS_LEN_W-1:0]  axis_len_reg;
  logic [INNER_CNT_W-1:0] inner_cnt_reg;
  logic [KIND_W-1:0]      kind_reg;
  logic [DATA_W-1:0]      best_value [AMR_MAX_INNER];
  logic [POS_W-1:0]       best_pos   [AMR_MAX_INNER];
  int unsigned            axis_pos;
  int unsigned            inner_pos;
  logic [POS_W-1:0]       expected_min_q [$];
  logic [POS_W-1:0]       want_min;

  // NaN sits above infinity in magnitude; signed zeros tie.
  function automatic bit ieee_less(logic [63:0] a, logic [63:0] b, int w, int m);
    logic [63:0] mag_mask;
    logic [63:0] inf_mag;
    logic [63:0] ma;
    logic [63:0] mb;
    bit          sa;
    bit          sb;
    mag_mask = {64{1'b1}} >> (65 - w);
    inf_mag  = mag_mask & ~((64'd1 << m) - 64'd1);
    ma       = a & mag_mask;
    mb       = b & mag_mask;
    sa       = a[w-1];
    sb       = b[w-1];
    if (ma > inf_mag || mb > inf_mag) return 1'b0;
    if (ma == 64'd0 && mb == 64'd0) return 1'b0;
    if (sa != sb) return sa;
    return sa ? (ma > mb) : (ma < mb);
  endfunction

  function automatic bit elem_less(logic [63:0] a, logic [63:0] b, logic [KIND_W-1:0] kind);
    case (kind)
      KIND_SIGNED: return ((a & ELEM_MASK) ^ ELEM_SIGN) < ((b & ELEM_MASK) ^ ELEM_SIGN);
      KIND_HALF:   return ieee_less(a, b, 16, 10);
      KIND_SINGLE: return ieee_less(a, b, 32, 23);
      KIND_DOUBLE: return ieee_less(a, b, 64, 52);
      default:     return (a & ELEM_MASK) < (b & ELEM_MASK);
    endcase
  endfunction

  task automatic advance_argmin(input logic [DATA_W-1:0] elem);
    int unsigned alen;
    int unsigned icnt;
    int unsigned slot;
    bit          at_end;
    alen   = (axis_len_reg == 0) ? 1 : ((axis_len_reg > MAX_AXIS) ? MAX_AXIS : axis_len_reg);
    icnt   = (inner_cnt_reg == 0) ? 1 :
             ((inner_cnt_reg > AMR_MAX_INNER) ? AMR_MAX_INNER : inner_cnt_reg);
    slot   = inner_pos % AMR_MAX_INNER;
    at_end = (axis_pos >= alen - 1);
    if (axis_pos == 0) begin
      best_value[slot] = elem;
      best_pos[slot]   = '0;
    end else if (elem_less(elem, best_value[slot], kind_reg)) begin
      best_value[slot] = elem;
      best_pos[slot]   = POS_W'(axis_pos);
    end
    if (at_end) expected_min_q.push_back(best_pos[slot]);
    if (inner_pos + 1 >= icnt) begin
      inner_pos = 0;
      axis_pos  = at_end ? 0 : ((axis_pos + 1) & 32'hFFFF);
    end else begin
      inner_pos = (inner_pos + 1) & 32'h3FF;
    end
  endtask

  task automatic report_mismatch(string what, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
    $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      axis_len_reg  = 1;
      inner_cnt_reg = 1;
      kind_reg      = KIND_SIGNED;
      axis_pos      = 0;
      inner_pos     = 0;
      expected_min_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_AXIS_LENGTH: axis_len_reg  = cfg_data[AXIS_LEN_W-1:0];
          CFG_INNER_COUNT: inner_cnt_reg = cfg_data[INNER_CNT_W-1:0];
          CFG_DATA_KIND:   kind_reg      = cfg_data[KIND_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) advance_argmin(in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_min_q.size() == 0) begin
          report_mismatch("min_index with nothing pending", out_tdata, '0);
        end else begin
          want_min = expected_min_q.pop_front();
          if (out_tdata !== want_min) report_mismatch("min_index", out_tdata, want_min);
        end
      end
    end
    pending = expected_min_q.size();
  end

endmodule

// File: tb/tb_axis_argmin_reducer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_axis_argmin_reducer
// Drives element frames through the argmin reducer under every data kind,
// clamped and extreme shapes, a reshape in the middle of a frame, a long
// output hold-off and several idling patterns on both sides; a separate
// checker predicts and compares each min_index word.
// ----------------------------------------------------------------------------
module tb_axis_argmin_reducer;
  import amr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int SMALL_WORDS    = 1170;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;
  typedef enum int { STIM_MIX, STIM_RAMP, STIM_LIST } stim_style_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [DATA_W-1:0]     in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [POS_W-1:0]      out_tdata;
  logic                  cfg_ready;

  int                mismatches;
  int                pending;
  int                idle_pct;
  int                stall_pct;
  int                hold_token;
  int                hold_seen;
  int                hold_left;
  int                quiet_cycles;
  int                words_sent;
  int                frame_words;
  int                phase;
  int                pick_alen;
  int                pick_icnt;
  logic [KIND_W-1:0] cur_kind;
  logic [63:0]       directed_q [$];

  axis_argmin_reducer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  argmin_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] special_elem(logic [KIND_W-1:0] kind, int pick);
    int          w;
    int          m;
    logic [63:0] sgn;
    logic [63:0] ex;
    logic [63:0] v;
    case (kind)
      KIND_HALF:   begin w = 16; m = 10; end
      KIND_SINGLE: begin w = 32; m = 23; end
      KIND_DOUBLE: begin w = 64; m = 52; end
      default:     begin w = 0;  m = 0;  end
    endcase
    if (w == 0) begin
      case (pick % 6)
        0:       v = 64'd0;
        1:       v = {64{1'b1}};
        2:       v = 64'd1;
        3:       v = {1'b1, 63'd0};
        4:       v = {1'b0, {63{1'b1}}};
        default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      return v;
    end
    sgn = 64'd1 << (w - 1);
    ex  = (sgn - 64'd1) & ~((64'd1 << m) - 64'd1);
    case (pick)
      0:       v = 64'd0;
      1:       v = sgn;
      2:       v = ex;
      3:       v = sgn | ex;
      4:       v = ex | 64'd1;
      5:       v = sgn | ex | (64'd1 << (m - 1));
      6:       v = 64'd1;
      7:       v = ex - 64'd1;
      8:       v = sgn | (ex - 64'd1);
      9:       v = 64'd1 << m;
      10:      v = sgn | 64'd1;
      default: v = (64'd1 << m) - 64'd1;
    endcase
    if (w < 64 && $urandom_range(0, 1) == 1) v = v | ({$urandom, $urandom} << w);
    return v;
  endfunction

  function automatic logic [63:0] gen_elem(logic [KIND_W-1:0] kind);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return {$urandom, $urandom};
    if (pick < 7) return 64'($urandom_range(0, 3));
    return special_elem(kind, $urandom_range(0, 11));
  endfunction

  task automatic set_mode(idle_mode_t mode);
    idle_pct  = (mode == IDLE_SENDER) ? 79 : ((mode == IDLE_BOTH) ? 6 : 0);
    stall_pct = (mode == IDLE_RECEIVER) ? 79 : ((mode == IDLE_BOTH) ? 6 : 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(int alen, int icnt, logic [KIND_W-1:0] kind);
    write_reg(CFG_AXIS_LENGTH, CFG_DATA_W'(alen));
    write_reg(CFG_INNER_COUNT, CFG_DATA_W'(icnt) | (CFG_DATA_W'($urandom) << INNER_CNT_W));
    write_reg(CFG_DATA_KIND, CFG_DATA_W'(kind) | (CFG_DATA_W'($urandom) << KIND_W));
    cur_kind    = kind;
    frame_words = ((alen == 0) ? 1 : ((alen > 65536) ? 65536 : alen)) *
                  ((icnt == 0) ? 1 : ((icnt > AMR_MAX_INNER) ? AMR_MAX_INNER : icnt));
  endtask

  task automatic send_words(int count, stim_style_t style);
    for (int i = 0; i < count; i++) begin
      while ($urandom_range(0, 99) < idle_pct) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      case (style)
        STIM_RAMP: in_tdata <= 64'(65535 - i);
        STIM_LIST: in_tdata <= directed_q[i];
        default:   in_tdata <= gen_elem(cur_kind);
      endcase
      do @(posedge clk); while (!in_tready);
      @(negedge clk);
      words_sent++;
    end
  endtask

  // drop valid, wait for every predicted word, then let the pipeline empty
  task automatic settle_block();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(int alen, int icnt, logic [KIND_W-1:0] kind, idle_mode_t mode,
                           int frames, stim_style_t style);
    configure(alen, icnt, kind);
    set_mode(mode);
    send_words(frame_words * frames, style);
    settle_block();
  endtask

  initial begin
    set_mode(IDLE_NONE);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    cur_kind = KIND_SIGNED;

    directed_q = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
    send_words(2, STIM_LIST);
    settle_block();
    directed_q = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                   64'h7FFF_FFFF_FFFF_FFFF};
    run_phase(4, 1, KIND_SIGNED, IDLE_NONE, 1, STIM_LIST);
    directed_q = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 64'd1};
    run_phase(4, 1, KIND_UNSIGNED, IDLE_NONE, 1, STIM_LIST);
    directed_q = '{64'hDEAD_BEEF_CAFE_0000, 64'h8000, 64'h7E00, 64'hFC00};
    run_phase(4, 1, KIND_HALF, IDLE_NONE, 1, STIM_LIST);
    directed_q = '{64'h7FC0_0000, 64'h3F80_0000, 64'hBF80_0000, 64'hBF80_0000};
    run_phase(4, 1, KIND_SINGLE, IDLE_NONE, 1, STIM_LIST);
    directed_q = '{64'h7FF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
                   64'h8000_0000_0000_0000, 64'd1};
    run_phase(4, 1, KIND_DOUBLE, IDLE_NONE, 1, STIM_LIST);
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));

    run_phase(5, 3, KIND_UNSIGNED, IDLE_NONE, 8, STIM_MIX);
    run_phase(1, 1, KIND_SIGNED, IDLE_SENDER, 60, STIM_MIX);
    run_phase(7, 4, KIND_HALF, IDLE_RECEIVER, 5, STIM_MIX);
    run_phase(3, 16, KIND_SINGLE, IDLE_BOTH, 3, STIM_MIX);
    run_phase(2, 2, KIND_DOUBLE, IDLE_NONE, 30, STIM_MIX);
    run_phase(0, 0, 3'd5, IDLE_RECEIVER, 40, STIM_MIX);
    run_phase(16, 1, 3'd7, IDLE_SENDER, 8, STIM_MIX);
    run_phase(4, 8, 3'd6, IDLE_BOTH, 4, STIM_MIX);

    // stop two rows and three words into a frame, then shrink the shape
    configure(5, 4, KIND_UNSIGNED);
    set_mode(IDLE_NONE);
    send_words(31, STIM_MIX);
    settle_block();
    write_reg(CFG_AXIS_LENGTH, CFG_DATA_W'(2));
    write_reg(CFG_INNER_COUNT, CFG_DATA_W'(2));
    set_mode(IDLE_RECEIVER);
    send_words(41, STIM_MIX);
    settle_block();

    // hold the output while words keep coming, then pause until drained
    configure(1, 1, KIND_W'($urandom_range(0, 4)));
    set_mode(IDLE_NONE);
    hold_token <= hold_token + 1;
    send_words(60, STIM_MIX);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    send_words(40, STIM_MIX);
    settle_block();

    phase = 0;
    while (words_sent < SMALL_WORDS) begin
      pick_alen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      pick_icnt = $urandom_range(0, 20);
      configure(pick_alen, pick_icnt, KIND_W'($urandom_range(0, 7)));
      set_mode(idle_mode_t'(phase % 4));
      send_words(frame_words * ((frame_words >= 60) ? 1 : (60 / frame_words)), STIM_MIX);
      settle_block();
      phase++;
    end

    // advance part way along a clamped inner count, then close the row early
    configure(1, 11'h7FF, KIND_SINGLE);
    set_mode(IDLE_BOTH);
    send_words(64, STIM_MIX);
    settle_block();
    write_reg(CFG_INNER_COUNT, CFG_DATA_W'(64));
    send_words(1, STIM_MIX);
    settle_block();

    // count along a clamped axis length, then end the run by shrinking it
    configure(17'h1FFFF, 1, KIND_UNSIGNED);
    set_mode(IDLE_NONE);
    send_words(100, STIM_RAMP);
    settle_block();
    write_reg(CFG_AXIS_LENGTH, CFG_DATA_W'(2));
    send_words(1, STIM_MIX);
    settle_block();

    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
